[hw/rtl/me31_pkg.sv]
// ============================================================================
// me31_pkg: shared types and constants for the Mersenne-31 exponentiator
// Holds the prime, the residue width, the sequencer states and the folding
// function that reduces a value modulo 2^31-1.
// ============================================================================
package me31_pkg;

    // Width of one residue modulo the prime.
    localparam int unsigned RES_W = 31;

    // The Mersenne prime 2^31 - 1.
    localparam logic [RES_W-1:0] MERSENNE_P = 31'h7FFF_FFFF;

    // Sequencer states of the exponentiator.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } me31_state_t;

    // Reduce a 33-bit value modulo 2^31-1. Since 2^31 is congruent to 1,
    // the upper bits fold onto the lower ones; the folded sum stays below
    // twice the prime, so one compare and subtract finishes the job.
    function automatic logic [RES_W-1:0] fold33(input logic [32:0] value);
        logic [RES_W:0] folded;
        logic [RES_W:0] trimmed;
        folded  = {1'b0, value[RES_W-1:0]} + {30'd0, value[32:31]};
        trimmed = folded - {1'b0, MERSENNE_P};
        if (folded >= {1'b0, MERSENNE_P})
        begin
            fold33 = trimmed[RES_W-1:0];
        end
        else
        begin
            fold33 = folded[RES_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/mod_exp_mersenne31.sv]
// ============================================================================
// mod_exp_mersenne31: modular exponentiation modulo 2^31-1
// Computes base^exponent mod 2^31-1 by right-to-left square-and-multiply
// on one shared, two-stage modular multiplier.
// ============================================================================
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) takes one beat per job:
// the 64-bit base in the low half and the 64-bit exponent in the high half.
// The master channel (m_tvalid, m_tready, m_tdata) returns one beat per job
// carrying the 31-bit residue. Only the low EXP_BITS exponent bits are used.
// After a beat is accepted the block reduces the base, then takes each
// exponent bit through a square state that issues the square and a
// multiply state that issues the multiply, whose product the accumulator
// keeps only when the bit is set; the split follows from the multiplier
// registering its product before the fold. A final state settles the
// accumulator and loads the output register. s_tready is high only while
// the sequencer is idle; it does not wait for the result to be taken,
// because the result sits in its own output register. If the receiver
// stalls and a second result is ready, the sequencer holds it until the
// register frees.
// Reset clears the sequencer and the output valid; no job is kept.
// ============================================================================
module mod_exp_mersenne31
#(
    parameter int EXP_BITS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] base_value, [127:64] exponent_value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // [30:0] power_result, [31] zero fill
);
    import me31_pkg::*;

    localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(EXP_BITS - 1);

    me31_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [RES_W-1:0]    out_data_reg, out_data_next;
    logic [63:0]         base_reg, base_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [RES_W-1:0]    sq_reg, sq_next;
    logic [RES_W-1:0]    acc_reg, acc_next;
    logic [RES_W-1:0]    mul_a, mul_b, mul_res;
    logic [RES_W-1:0]    acc_now;
    logic [32:0]         base_sum;
    logic                in_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    // Shared modular multiplier.
    me31_mulmod u_mulmod
    (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_res)
    );

    // Fold the 64-bit base as three 31/31/2-bit pieces.
    assign base_sum = {2'b00, base_reg[30:0]} + {2'b00, base_reg[61:31]}
                    + {31'd0, base_reg[63:62]};

    // Accumulator including a multiply that lands in this cycle.
    assign acc_now = pend_reg ? mul_res : acc_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        sq_reg       <= sq_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // Sequencer: next state, operand selection and register updates.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        mul_a          = sq_reg;
        mul_b          = sq_reg;

        // The receiver drains the output register.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    base_next  = s_tdata[63:0];
                    exp_next   = s_tdata[64 +: EXP_BITS];
                    acc_next   = RES_W'(1);
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                sq_next    = fold33(base_sum);
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                // Issue the square; retire a pending multiply.
                acc_next   = acc_now;
                pend_next  = 1'b0;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                // The square is ready; issue the multiply with the old square.
                mul_a     = acc_reg;
                mul_b     = sq_reg;
                sq_next   = mul_res;
                pend_next = exp_reg[0];
                exp_next  = exp_reg >> 1;
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH:
            begin
                acc_next  = acc_now;
                pend_next = 1'b0;
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = acc_now;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted beat always starts with the base reduction.
    a_start_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg == ST_REDUCE)
        else $error("accepted beat did not start the base reduction");

    // A multiply step always follows its square step.
    a_mult_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MULT |-> $past(state_reg) == ST_SQUARE)
        else $error("multiply step without a preceding square");

    // The running square stays a proper residue.
    a_square_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE || state_reg == ST_MULT) |-> sq_reg != MERSENNE_P)
        else $error("running square not reduced");

    // A delivered result is always below the prime.
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:0] != MERSENNE_P && !m_tdata[31])
        else $error("result not reduced");

endmodule

[hw/rtl/me31_mulmod.sv]
// ============================================================================
// me31_mulmod: modular multiplier for the prime 2^31-1
// Multiplies two residues into a registered 62-bit product, then folds
// that product back below the prime in the following cycle.
// ============================================================================
module me31_mulmod
(
    input  logic                      clk,
    input  logic [me31_pkg::RES_W-1:0] op_a,
    input  logic [me31_pkg::RES_W-1:0] op_b,
    output logic [me31_pkg::RES_W-1:0] product
);
    import me31_pkg::*;

    logic [2*RES_W-1:0] prod_reg;
    logic [32:0]        half_sum;

    // The raw product is registered before it is reduced.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Add the two 31-bit halves, then fold and trim the sum.
    assign half_sum = {2'b00, prod_reg[RES_W-1:0]} + {2'b00, prod_reg[2*RES_W-1:RES_W]};
    assign product  = fold33(half_sum);

endmodule

[verif/me31_power_checker.sv]
// ============================================================================
// me31_power_checker: result checker for the Mersenne-31 exponentiator
// Watches both stream channels of the block. For every job accepted on the
// input side it works out base^exponent mod 2^31-1 by its own square-and-
// multiply and queues the expected residue. Each result beat is compared
// with the oldest queued residue. The count of failures and the number of
// results still owed go back to the testbench top.
// ============================================================================
`timescale 1ns / 1ps

module me31_power_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] base_value, [127:64] exponent_value
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,   // [30:0] power_result, [31] zero fill
    output int           outstanding,
    output int           fail_count
);
    import me31_pkg::*;

    // Number of exponent bits the block scans.
    localparam int unsigned SCAN_BITS = 64;

    // One job whose residue has not come back yet.
    typedef struct {
        logic [63:0]      base_value;
        logic [63:0]      exponent_value;
        logic [RES_W-1:0] power_result;
    } power_job_t;

    power_job_t owed_powers[$];
    int         errors = 0;

    assign fail_count = errors;

    initial
    begin
        outstanding = 0;
    end

    // Right-to-left square-and-multiply; every operand is already below the
    // prime, so each product fits in 62 bits before it is reduced.
    function automatic logic [RES_W-1:0] power_mod_prime(input logic [63:0] base_value,
                                                         input logic [63:0] exponent_value);
        logic [63:0] prime;
        logic [63:0] acc;
        logic [63:0] square;
        prime  = {33'd0, MERSENNE_P};
        acc    = 64'd1;
        square = base_value % prime;
        for (int unsigned bit_idx = 0; bit_idx < SCAN_BITS; bit_idx++)
        begin
            if (exponent_value[bit_idx])
            begin
                acc = (acc * square) % prime;
            end
            square = (square * square) % prime;
        end
        return acc[RES_W-1:0];
    endfunction

    // Track beats on both channels and compare results in order.
    always @(posedge clk)
    begin
        power_job_t job;
        logic       in_beat;
        logic       out_beat;
        in_beat  = rst_n && s_tvalid && s_tready;
        out_beat = rst_n && m_tvalid && m_tready;

        if (in_beat)
        begin
            job.base_value     = s_tdata[63:0];
            job.exponent_value = s_tdata[127:64];
            job.power_result   = power_mod_prime(s_tdata[63:0], s_tdata[127:64]);
            owed_powers        = {owed_powers, job};
        end

        if (out_beat)
        begin
            if (owed_powers.size() == 0)
            begin
                errors++;
                $display("%0t: power_result expected none, actual %0d",
                         $time, m_tdata[RES_W-1:0]);
            end
            else
            begin
                job = owed_powers.pop_front();
                if (m_tdata[RES_W-1:0] !== job.power_result)
                begin
                    errors++;
                    $display("%0t: power_result expected %0d, actual %0d (base %h, exponent %h)",
                             $time, job.power_result, m_tdata[RES_W-1:0],
                             job.base_value, job.exponent_value);
                end
            end
        end

        outstanding <= owed_powers.size();
    end

endmodule

[verif/mod_exp_mersenne31_tb.sv]
// ============================================================================
// mod_exp_mersenne31_tb: testbench top for the Mersenne-31 exponentiator
// Drives jobs into the block with random gaps, a steady stretch and one long
// receiver hold-off that backs the block up. A directed set covers zero
// exponents, multiples of the prime and the extremes of both fields; random
// jobs follow. The checker beside the block predicts and compares.
// ============================================================================
`timescale 1ns / 1ps

module mod_exp_mersenne31_tb;

    import me31_pkg::*;

    localparam int unsigned RANDOM_JOBS   = 1600;
    localparam int unsigned DRAIN_CYCLES  = 140;
    localparam int unsigned HOLD_CYCLES   = 500;
    localparam int unsigned HOLD_AT_JOB   = 300;
    localparam int unsigned STEADY_FIRST  = 800;
    localparam int unsigned STEADY_LAST   = 1100;
    localparam logic [63:0] PRIME64       = {33'd0, MERSENNE_P};

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;    // [63:0] base_value, [127:64] exponent_value
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;          // [30:0] power_result, [31] zero fill

    logic         hold_off = 1'b0;
    logic         steady   = 1'b0;
    int unsigned  jobs_sent = 0;
    int           outstanding;
    int           fail_count;

    always #5 clk = ~clk;

    mod_exp_mersenne31 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    me31_power_checker power_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Bases: full-width in three draws of eight, with multiples of the prime,
    // values near the prime and saturated upper halves mixed in.
    function automatic logic [63:0] pick_base();
        logic [63:0] multiple;
        case ($urandom_range(0, 7))
            0, 1, 2: return rand64();
            3:
            begin
                multiple = {31'd0, 1'(($urandom_range(0, 1))), $urandom};
                return multiple * PRIME64;
            end
            4:       return PRIME64 + 64'($urandom_range(0, 3)) - 64'd2;
            5:       return 64'($urandom_range(0, 3));
            6:       return {33'd0, 31'($urandom)};
            default: return {32'hFFFF_FFFF, $urandom};
        endcase
    endfunction

    // Exponents: full-width in three draws of eight, with small, single-bit,
    // nearly full and Fermat-style values mixed in.
    function automatic logic [63:0] pick_exponent();
        case ($urandom_range(0, 7))
            0, 1, 2: return rand64();
            3:       return 64'($urandom_range(0, 15));
            4:       return 64'd1 << $urandom_range(0, 63);
            5:       return ~(64'd1 << $urandom_range(0, 63));
            6:       return PRIME64 - 64'($urandom_range(1, 2));
            default: return {32'd0, $urandom};
        endcase
    endfunction

    // Offer one job and hold it until the block takes the beat.
    task automatic send_job(input logic [63:0] base_value, input logic [63:0] exponent_value);
        int unsigned gap;
        if (!steady && $urandom_range(0, 99) < 5)
        begin
            gap = $urandom_range(1, 140);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {exponent_value, base_value};
        do
            @(posedge clk);
        while (!s_tready);
        jobs_sent++;
    endtask

    // Receiver side: random stalls, none during the steady stretch.
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            m_tready <= 1'b0;
        end
        else if (steady)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    // One long receiver hold-off while the sender keeps offering jobs.
    initial
    begin
        wait (jobs_sent >= HOLD_AT_JOB);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Safety net in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("mod_exp_mersenne31: mismatch");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero exponent, including bases that vanish modulo the prime.
        send_job(64'd0, 64'd0);
        send_job(PRIME64, 64'd0);
        send_job(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        // Bases that are multiples of the prime with nonzero exponents.
        send_job(64'd0, 64'd1);
        send_job(PRIME64, 64'd5);
        send_job(PRIME64 * 64'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_job(PRIME64 * 64'h1_FFFF_FFFF, 64'h8000_0000_0000_0000);
        // Field extremes and values around the prime.
        send_job(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_job(64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
        send_job(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_job(PRIME64 - 64'd1, 64'd3);
        send_job(PRIME64 - 64'd1, 64'd2);
        send_job(PRIME64 + 64'd1, 64'h1234_5678_9ABC_DEF0);
        send_job(64'd2, 64'd30);
        send_job(64'd2, 64'd31);
        send_job(64'd3, 64'h8000_0000_0000_0000);
        // Fermat exponent gives one, its predecessor the inverse.
        send_job(64'd7, PRIME64 - 64'd1);
        send_job(64'd7, PRIME64 - 64'd2);
        send_job(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_job(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_job(64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);

        for (int unsigned job_idx = 0; job_idx < RANDOM_JOBS; job_idx++)
        begin
            steady = (job_idx >= STEADY_FIRST) && (job_idx < STEADY_LAST);
            send_job(pick_base(), pick_exponent());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Let the last results drain, then give the block a little longer.
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
        begin
            $display("mod_exp_mersenne31: match");
        end
        else
        begin
            $display("mod_exp_mersenne31: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/me31_pkg.sv
hw/rtl/me31_mulmod.sv
hw/rtl/mod_exp_mersenne31.sv
verif/me31_power_checker.sv
verif/mod_exp_mersenne31_tb.sv
